// ===== rtl/ftcm_pkg.sv =====
// Shared types, codes and constants of the frame time capture monitor.
// Used by the top, the controller, the datapath and the checkers; depends on nothing else.
`default_nettype none

package ftcm_pkg;

    localparam int unsigned TS_W           = 48;
    localparam int unsigned PER_W          = 29;
    localparam int unsigned DIV_W          = 49;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned MAX_FRAMES_DEF = 131072;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_FRAME  = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // Status codes of a result word.
    localparam logic [3:0] ST_STARTED   = 4'd0;
    localparam logic [3:0] ST_PRIMED    = 4'd1;
    localparam logic [3:0] ST_WARMUP    = 4'd2;
    localparam logic [3:0] ST_RECORDED  = 4'd3;
    localparam logic [3:0] ST_COMPLETE  = 4'd4;
    localparam logic [3:0] ST_INACTIVE  = 4'd5;
    localparam logic [3:0] ST_NO_ADV    = 4'd6;
    localparam logic [3:0] ST_CAP       = 4'd7;
    localparam logic [3:0] ST_METRIC    = 4'd8;
    localparam logic [3:0] ST_NO_FRAMES = 4'd9;

    // Metric identifiers.
    localparam logic [3:0] M_COUNT     = 4'd0;
    localparam logic [3:0] M_TOTAL     = 4'd1;
    localparam logic [3:0] M_WORST     = 4'd2;
    localparam logic [3:0] M_MIN_FPS   = 4'd3;
    localparam logic [3:0] M_AVG_FPS   = 4'd4;
    localparam logic [3:0] M_P50       = 4'd5;
    localparam logic [3:0] M_P95       = 4'd6;
    localparam logic [3:0] M_P99       = 4'd7;
    localparam logic [3:0] M_OVER_FAST = 4'd8;
    localparam logic [3:0] M_OVER_FTOL = 4'd9;
    localparam logic [3:0] M_OVER_SLOW = 4'd10;
    localparam logic [3:0] M_OVER_STOL = 4'd11;
    localparam logic [3:0] M_FLAGS     = 4'd12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BFAST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BSLOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;

    localparam logic [25:0] WARMUP_RST   = 26'd0;
    localparam logic [28:0] DURATION_RST = 29'd10000000;
    localparam logic [19:0] BFAST_RST    = 20'd16667;
    localparam logic [19:0] BSLOW_RST    = 20'd33333;
    localparam logic [19:0] TOL_RST      = 20'd1000;

    // One second in microseconds, scaled by 256 for 8 fraction bits.
    localparam logic [27:0] FPS_SCALE = 28'd256000000;
    localparam logic [6:0]  PCT_DIV   = 7'd100;
    localparam logic [6:0]  PCT_HALF  = 7'd50;

    // Divider operations.
    localparam logic [1:0] OP_RANK    = 2'd0;
    localparam logic [1:0] OP_MIN_FPS = 2'd1;
    localparam logic [1:0] OP_AVG_FPS = 2'd2;
    localparam logic [1:0] OP_PCT     = 2'd3;

    typedef struct packed {
        logic [1:0]      func;
        logic [TS_W-1:0] timestamp_us;
    } in_word_t;

    typedef struct packed {
        logic [3:0]      status;
        logic [3:0]      metric_id;
        logic [TS_W-1:0] metric_value;
        logic            last;
    } out_word_t;

    typedef struct packed {
        logic       load_in;
        logic       start_clr;
        logic       fr_eval;
        logic       prime;
        logic       deact;
        logic       set_prev;
        logic       record;
        logic       div_start;
        logic       div_store;
        logic       rank_store;
        logic       scan_start;
        logic       scan_search;
        logic       srch_update;
        logic       emit;
        logic [1:0] op;
        logic [1:0] sel;
        logic [4:0] bit_idx;
        logic [3:0] code;
        logic [3:0] id;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       active;
        logic       primed;
        logic       le;
        logic       warm;
        logic       cap;
        logic       complete;
        logic       empty;
        logic       div_busy;
        logic       scan_busy;
        logic       out_free;
    } stat_t;

    function automatic logic [6:0] pct_q(input logic [1:0] sel);
        logic [6:0] q;
        case (sel)
            2'd0:    q = 7'd50;
            2'd1:    q = 7'd95;
            default: q = 7'd99;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/frame_time_capture_monitor_top.sv =====
// Top level of the frame time capture monitor: controller plus datapath.
// Depends on ftcm_pkg, ftcm_ctrl and ftcm_dp.
`default_nettype none

// The monitor takes one input word at a time. A start word, like a report
// over an empty store, goes from the dispatch step straight to its result
// word; a frame boundary word passes the dispatch, evaluate and decide steps
// of the controller, and the completion step too when the frame is recorded,
// before its result word. A report word walks the period store once for the
// budget counts and the worst period, then 29 more times (one pass per bit of
// a stored period) to select the six order statistics behind the three
// percentiles; every pass reads one stored period per cycle from the single
// read port of the store. The two frame rate divisions use the bit-serial
// divider; the three rank divisions and the three interpolations divide by
// 100 through reciprocal multiplication. The metric words then follow, each
// loaded when the output register is free. The result word sits in an output
// register, so the next input word can be accepted the cycle after it is
// loaded, while it waits. The period store has no reset; only entries below
// the frame count are ever read. Configuration writes are taken in any cycle
// and belong in idle time.
module frame_time_capture_monitor_top import ftcm_pkg::*; #(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences each word; it sees the datapath only
    // through the status struct.
    ftcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the registers, the store, the divider and the
    // output register.
    ftcm_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/ftcm_ram.sv =====
// Generic simple dual port RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module ftcm_ram #(
    parameter int unsigned WIDTH = 29,
    parameter int unsigned DEPTH = 131072
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ftcm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Stands alone; no package needed.
`default_nettype none

module ftcm_div #(
    parameter int unsigned DW = 49,
    parameter int unsigned VW = 48
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               busy,
    output logic      [DW-1:0] quot
);

    localparam int unsigned NW = $clog2(DW + 1);

    logic          busy_reg;
    logic [NW-1:0] cnt_reg;
    logic [DW-1:0] q_reg;
    logic [VW-1:0] r_reg;
    logic [VW-1:0] d_reg;
    logic [VW:0]   trial;
    logic [VW+1:0] diff;

    assign trial = {r_reg, q_reg[DW-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(DW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - NW'(1);
            if (cnt_reg == NW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The partial remainder stays below the divisor, so it fits VW bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[VW+1]) begin
                r_reg <= diff[VW-1:0];
                q_reg <= {q_reg[DW-2:0], 1'b1};
            end else begin
                r_reg <= trial[VW-1:0];
                q_reg <= {q_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== rtl/ftcm_ctrl.sv =====
// Controller state machine of the frame time capture monitor.
// Depends on ftcm_pkg for the command and status structs and the codes.
`default_nettype none

module ftcm_ctrl import ftcm_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_F_EVAL   = 4'd2;
    localparam logic [3:0] S_F_DEC    = 4'd3;
    localparam logic [3:0] S_F_FIN    = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_R_RANK   = 4'd6;
    localparam logic [3:0] S_R_RANKW  = 4'd7;
    localparam logic [3:0] S_R_STATS  = 4'd8;
    localparam logic [3:0] S_R_STATSW = 4'd9;
    localparam logic [3:0] S_R_PASS   = 4'd10;
    localparam logic [3:0] S_R_PASSW  = 4'd11;
    localparam logic [3:0] S_R_CALC   = 4'd12;
    localparam logic [3:0] S_R_CALCW  = 4'd13;

    localparam logic [4:0] TOP_BIT = 5'(PER_W - 1);

    logic [3:0] state_reg, state_next;
    logic [3:0] code_reg, code_next;
    logic [3:0] id_reg, id_next;
    logic [1:0] sel_reg, sel_next;
    logic [4:0] bit_reg, bit_next;
    logic [2:0] step_reg, step_next;
    logic       last_now;

    assign last_now = (code_reg != ST_METRIC) || (id_reg == M_FLAGS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_STARTED;
            id_reg    <= '0;
            sel_reg   <= '0;
            bit_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            id_reg    <= id_next;
            sel_reg   <= sel_next;
            bit_reg   <= bit_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        sel_next    = sel_reg;
        bit_next    = bit_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.bit_idx = bit_reg;
        cmd.sel     = sel_reg;
        cmd.code    = code_reg;
        cmd.id      = id_reg;
        cmd.last    = last_now;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    id_next     = '0;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.func)
                    FUNC_START: begin
                        cmd.start_clr = 1'b1;
                        code_next     = ST_STARTED;
                        state_next    = S_EMIT;
                    end
                    FUNC_FRAME: begin
                        state_next = S_F_EVAL;
                    end
                    FUNC_REPORT: begin
                        if (stat.empty) begin
                            code_next  = ST_NO_FRAMES;
                            state_next = S_EMIT;
                        end else begin
                            sel_next   = '0;
                            state_next = S_R_RANK;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_F_EVAL: begin
                cmd.fr_eval = 1'b1;
                state_next  = S_F_DEC;
            end
            S_F_DEC: begin
                state_next = S_EMIT;
                if (!stat.active) begin
                    code_next = ST_INACTIVE;
                end else if (!stat.primed) begin
                    cmd.prime = 1'b1;
                    code_next = ST_PRIMED;
                end else if (stat.le) begin
                    cmd.deact = 1'b1;
                    code_next = ST_NO_ADV;
                end else if (stat.warm) begin
                    cmd.set_prev = 1'b1;
                    code_next    = ST_WARMUP;
                end else if (stat.cap) begin
                    cmd.deact = 1'b1;
                    code_next = ST_CAP;
                end else begin
                    cmd.record = 1'b1;
                    state_next = S_F_FIN;
                end
            end
            S_F_FIN: begin
                if (stat.complete) begin
                    cmd.deact = 1'b1;
                    code_next = ST_COMPLETE;
                end else begin
                    code_next = ST_RECORDED;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (last_now) begin
                        state_next = S_IDLE;
                    end else begin
                        id_next = id_reg + 4'd1;
                    end
                end
            end
            S_R_RANK: begin
                cmd.op        = OP_RANK;
                cmd.div_start = 1'b1;
                state_next    = S_R_RANKW;
            end
            S_R_RANKW: begin
                cmd.op = OP_RANK;
                if (!stat.div_busy) begin
                    cmd.rank_store = 1'b1;
                    if (sel_reg == 2'd2) begin
                        state_next = S_R_STATS;
                    end else begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_R_RANK;
                    end
                end
            end
            S_R_STATS: begin
                cmd.scan_start = 1'b1;
                state_next     = S_R_STATSW;
            end
            S_R_STATSW: begin
                if (!stat.scan_busy) begin
                    bit_next   = TOP_BIT;
                    state_next = S_R_PASS;
                end
            end
            S_R_PASS: begin
                cmd.scan_start  = 1'b1;
                cmd.scan_search = 1'b1;
                state_next      = S_R_PASSW;
            end
            S_R_PASSW: begin
                if (!stat.scan_busy) begin
                    cmd.srch_update = 1'b1;
                    if (bit_reg == 5'd0) begin
                        step_next  = '0;
                        state_next = S_R_CALC;
                    end else begin
                        bit_next   = bit_reg - 5'd1;
                        state_next = S_R_PASS;
                    end
                end
            end
            S_R_CALC, S_R_CALCW: begin
                case (step_reg)
                    3'd0:    cmd.op = OP_MIN_FPS;
                    3'd1:    cmd.op = OP_AVG_FPS;
                    default: cmd.op = OP_PCT;
                endcase
                cmd.sel = 2'(step_reg - 3'd2);
                if (state_reg == S_R_CALC) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_R_CALCW;
                end else if (!stat.div_busy) begin
                    cmd.div_store = 1'b1;
                    if (step_reg == 3'd4) begin
                        code_next  = ST_METRIC;
                        state_next = S_EMIT;
                    end else begin
                        step_next  = step_reg + 3'd1;
                        state_next = S_R_CALC;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ftcm_dp.sv =====
// Datapath of the frame time capture monitor: registers, capture state,
// period store, scan engine, divider and output register.
// Depends on ftcm_pkg, ftcm_ram and ftcm_div.
`default_nettype none

module ftcm_dp import ftcm_pkg::*; #(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire in_word_t              s_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    localparam int unsigned AW = $clog2(MAX_FRAMES);
    localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

    // Reciprocals of 100, rounded up: 2^36 / 100 for values below 2^29 and
    // 2^29 / 100 for values below 2^22.
    localparam logic [29:0] RECIP_A = 30'd687194768;
    localparam logic [22:0] RECIP_B = 23'd5368710;

    // Configuration registers.
    logic [25:0] warmup_reg;
    logic [28:0] duration_reg;
    logic [19:0] bfast_reg, bslow_reg, tol_reg;

    // Capture state.
    in_word_t       in_reg;
    logic           active_reg, primed_reg;
    logic [TS_W-1:0] first_reg, prev_reg, total_reg, per_reg;
    logic [CW-1:0]  fcnt_reg;
    logic           le_reg, warm_reg, cap_reg;

    // Report state.
    logic [CW-1:0]    rank_reg [6];
    logic [6:0]       rem_reg [3];
    logic [PER_W-1:0] ans_reg [6];
    logic [CW-1:0]    scnt_reg [6];
    logic [CW-1:0]    c_reg [4];
    logic [PER_W-1:0] max_reg;
    logic [TS_W-1:0]  minfps_reg, avgfps_reg;
    logic [TS_W-1:0]  pct_reg [3];

    // Scan engine.
    logic          run_reg, rvld_reg, search_reg;
    logic [CW-1:0] idx_reg;

    out_word_t out_reg;
    logic      mvalid_reg;

    logic [TS_W:0]    diff;
    logic [TS_W-1:0]  elapsed;
    logic [PER_W-1:0] per_sat;
    logic [PER_W-1:0] rdata;
    logic [PER_W-1:0] low_mask, bit_mask;
    logic [20:0]      fast_tol, slow_tol;
    logic             issue;

    logic [DIV_W-1:0] div_a, div_quot;
    logic [TS_W-1:0]  div_b;
    logic             div_busy;
    logic [CW+6:0]    rank_prod;
    logic [CW+27:0]   avg_prod;
    logic [TS_W-1:0]  tot_nz;
    logic [PER_W-1:0] pa, pb;
    logic [6:0]       prem;
    logic [CW-1:0]    lo_val, up_val;
    logic [CW:0]      lo_inc;
    logic [TS_W-1:0]  mval;

    // Division by 100 unit.
    logic             const_op, fps_start, c100_start;
    logic [2:0]       c100_cnt_reg;
    logic [PER_W-1:0] c100_t_reg;
    logic [6:0]       c100_m_reg;
    logic [22:0]      qa_reg;
    logic [6:0]       ra_reg;
    logic [29:0]      hi_reg;
    logic [21:0]      x2_reg;
    logic [15:0]      qb_reg;
    logic [58:0]      qa_prod;
    logic [PER_W-1:0] ra_full;
    logic [44:0]      qb_prod;
    logic [37:0]      pct_frac;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg   <= WARMUP_RST;
            duration_reg <= DURATION_RST;
            bfast_reg    <= BFAST_RST;
            bslow_reg    <= BSLOW_RST;
            tol_reg      <= TOL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WARMUP:   warmup_reg   <= cfg_data[25:0];
                CFG_DURATION: duration_reg <= cfg_data[28:0];
                CFG_BFAST:    bfast_reg    <= cfg_data[19:0];
                CFG_BSLOW:    bslow_reg    <= cfg_data[19:0];
                CFG_TOL:      tol_reg      <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Frame boundary evaluation.
    assign diff    = {1'b0, in_reg.timestamp_us} - {1'b0, prev_reg};
    assign elapsed = prev_reg - first_reg;
    assign per_sat = (per_reg[TS_W-1:PER_W] != '0) ? '1 : per_reg[PER_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.fr_eval) begin
            per_reg  <= diff[TS_W-1:0];
            le_reg   <= diff[TS_W] || (diff[TS_W-1:0] == '0);
            warm_reg <= elapsed < TS_W'(warmup_reg);
            cap_reg  <= fcnt_reg >= CW'(MAX_FRAMES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            primed_reg <= 1'b0;
            first_reg  <= '0;
            prev_reg   <= '0;
            total_reg  <= '0;
            fcnt_reg   <= '0;
        end else if (cmd.start_clr) begin
            active_reg <= 1'b1;
            primed_reg <= 1'b0;
            first_reg  <= '0;
            prev_reg   <= '0;
            total_reg  <= '0;
            fcnt_reg   <= '0;
        end else begin
            if (cmd.deact) begin
                active_reg <= 1'b0;
            end
            if (cmd.prime) begin
                primed_reg <= 1'b1;
                first_reg  <= in_reg.timestamp_us;
                prev_reg   <= in_reg.timestamp_us;
            end
            if (cmd.set_prev) begin
                prev_reg <= in_reg.timestamp_us;
            end
            if (cmd.record) begin
                prev_reg  <= in_reg.timestamp_us;
                total_reg <= total_reg + per_reg;
                fcnt_reg  <= fcnt_reg + CW'(1);
            end
        end
    end

    ftcm_ram #(
        .WIDTH (PER_W),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.record),
        .waddr (fcnt_reg[AW-1:0]),
        .wdata (per_sat),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Scan engine: walks the stored periods, one per cycle.
    assign issue = run_reg && (idx_reg < fcnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            rvld_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            rvld_reg <= issue;
            if (cmd.scan_start) begin
                run_reg <= 1'b1;
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end else if (run_reg && !rvld_reg) begin
                run_reg <= 1'b0;
            end
        end
    end

    assign bit_mask = PER_W'(1) << cmd.bit_idx;
    assign low_mask = bit_mask - PER_W'(1);
    assign fast_tol = {1'b0, bfast_reg} + {1'b0, tol_reg};
    assign slow_tol = {1'b0, bslow_reg} + {1'b0, tol_reg};

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            search_reg <= cmd.scan_search;
            for (int j = 0; j < 6; j++) begin
                scnt_reg[j] <= '0;
            end
            if (!cmd.scan_search) begin
                max_reg <= '0;
                for (int j = 0; j < 4; j++) begin
                    c_reg[j] <= '0;
                end
                for (int j = 0; j < 6; j++) begin
                    ans_reg[j] <= '0;
                end
            end
        end else if (rvld_reg) begin
            if (search_reg) begin
                for (int j = 0; j < 6; j++) begin
                    if (rdata <= (ans_reg[j] | low_mask)) begin
                        scnt_reg[j] <= scnt_reg[j] + CW'(1);
                    end
                end
            end else begin
                if (rdata > max_reg) begin
                    max_reg <= rdata;
                end
                if (rdata > PER_W'(bfast_reg)) c_reg[0] <= c_reg[0] + CW'(1);
                if (rdata > PER_W'(fast_tol))  c_reg[1] <= c_reg[1] + CW'(1);
                if (rdata > PER_W'(bslow_reg)) c_reg[2] <= c_reg[2] + CW'(1);
                if (rdata > PER_W'(slow_tol))  c_reg[3] <= c_reg[3] + CW'(1);
            end
        end else if (cmd.srch_update) begin
            // A bit stays clear when enough periods lie at or below the probe.
            for (int j = 0; j < 6; j++) begin
                if (!(scnt_reg[j] > rank_reg[j])) begin
                    ans_reg[j] <= ans_reg[j] | bit_mask;
                end
            end
        end
    end

    // Operand selection.
    assign tot_nz    = (total_reg == '0) ? TS_W'(1) : total_reg;
    assign rank_prod = (CW+7)'(fcnt_reg - CW'(1)) * (CW+7)'(pct_q(cmd.sel));
    assign avg_prod  = (CW+28)'(fcnt_reg) * (CW+28)'(FPS_SCALE);

    always_comb begin
        case (cmd.sel)
            2'd0: begin
                pa = ans_reg[0]; pb = ans_reg[1]; prem = rem_reg[0];
            end
            2'd1: begin
                pa = ans_reg[2]; pb = ans_reg[3]; prem = rem_reg[1];
            end
            default: begin
                pa = ans_reg[4]; pb = ans_reg[5]; prem = rem_reg[2];
            end
        endcase
    end

    // Rank and interpolation steps divide by 100 in a short multiply
    // pipeline; the frame rates go through the serial divider.
    assign const_op   = (cmd.op == OP_RANK) || (cmd.op == OP_PCT);
    assign fps_start  = cmd.div_start && !const_op;
    assign c100_start = cmd.div_start && const_op;

    always_comb begin
        case (cmd.op)
            OP_MIN_FPS: begin
                div_a = DIV_W'(FPS_SCALE) + DIV_W'(max_reg >> 1);
                div_b = TS_W'(max_reg);
            end
            default: begin
                div_a = DIV_W'(avg_prod) + DIV_W'(tot_nz >> 1);
                div_b = tot_nz;
            end
        endcase
    end

    ftcm_div #(
        .DW (DIV_W),
        .VW (TS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (fps_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    // The operand t is split as 100 * qa + ra. For an interpolation the
    // weighted difference d * 256 * rem over 100 is then qa * rem * 256 plus
    // (ra * rem * 256 + 50) / 100, which keeps every product small. Each
    // stage recomputes from the held operands every cycle; a rank is read from
    // qa_reg and ra_reg, a percentile from hi_reg and qb_reg.
    assign qa_prod  = 59'(c100_t_reg) * 59'(RECIP_A);
    assign ra_full  = c100_t_reg - PER_W'(30'(qa_reg) * 30'(PCT_DIV));
    assign qb_prod  = 45'(x2_reg) * 45'(RECIP_B);
    assign pct_frac = {hi_reg, 8'b0} + 38'(qb_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c100_cnt_reg <= '0;
        end else if (c100_start) begin
            c100_cnt_reg <= (cmd.op == OP_RANK) ? 3'd2 : 3'd4;
        end else if (c100_cnt_reg != 3'd0) begin
            c100_cnt_reg <= c100_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (c100_start) begin
            c100_t_reg <= (cmd.op == OP_RANK) ? PER_W'(rank_prod) : pb - pa;
            c100_m_reg <= prem;
        end
        qa_reg <= qa_prod[58:36];
        ra_reg <= ra_full[6:0];
        hi_reg <= 30'(qa_reg) * 30'(c100_m_reg);
        x2_reg <= {14'(ra_reg) * 14'(c100_m_reg), 8'b0} + 22'(PCT_HALF);
        qb_reg <= qb_prod[44:29];
    end

    assign lo_val = CW'(qa_reg);
    assign lo_inc = {1'b0, lo_val} + (CW+1)'(1);
    assign up_val = (lo_inc < {1'b0, fcnt_reg}) ? lo_inc[CW-1:0] : fcnt_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.rank_store) begin
            rank_reg[{cmd.sel, 1'b0}] <= lo_val;
            rank_reg[{cmd.sel, 1'b1}] <= up_val;
            rem_reg[cmd.sel]          <= ra_reg;
        end
        if (cmd.div_store) begin
            case (cmd.op)
                OP_MIN_FPS: minfps_reg <= (max_reg == '0) ? '0 : div_quot[TS_W-1:0];
                OP_AVG_FPS: avgfps_reg <= div_quot[TS_W-1:0];
                OP_PCT:     pct_reg[cmd.sel] <= TS_W'({pa, 8'b0}) + TS_W'(pct_frac);
                default: ;
            endcase
        end
    end

    // Metric selection and output register.
    always_comb begin
        case (cmd.id)
            M_COUNT:     mval = TS_W'(fcnt_reg);
            M_TOTAL:     mval = total_reg;
            M_WORST:     mval = TS_W'(max_reg);
            M_MIN_FPS:   mval = minfps_reg;
            M_AVG_FPS:   mval = avgfps_reg;
            M_P50:       mval = pct_reg[0];
            M_P95:       mval = pct_reg[1];
            M_P99:       mval = pct_reg[2];
            M_OVER_FAST: mval = TS_W'(c_reg[0]);
            M_OVER_FTOL: mval = TS_W'(c_reg[1]);
            M_OVER_SLOW: mval = TS_W'(c_reg[2]);
            M_OVER_STOL: mval = TS_W'(c_reg[3]);
            M_FLAGS:     mval = TS_W'({c_reg[3] == '0, c_reg[1] == '0});
            default:     mval = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            mvalid_reg <= 1'b1;
        end else if (m_ready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.status       <= cmd.code;
            out_reg.metric_id    <= (cmd.code == ST_METRIC) ? cmd.id : 4'd0;
            out_reg.metric_value <= (cmd.code == ST_METRIC) ? mval : '0;
            out_reg.last         <= cmd.last;
        end
    end

    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    assign stat.func      = in_reg.func;
    assign stat.active    = active_reg;
    assign stat.primed    = primed_reg;
    assign stat.le        = le_reg;
    assign stat.warm      = warm_reg;
    assign stat.cap       = cap_reg;
    assign stat.complete  = total_reg >= TS_W'(duration_reg);
    assign stat.empty     = (fcnt_reg == '0);
    assign stat.div_busy  = div_busy || (c100_cnt_reg != 3'd0);
    assign stat.scan_busy = run_reg;
    assign stat.out_free  = !mvalid_reg || m_ready;

endmodule

`default_nettype wire

// ===== rtl/ftcm_checker.sv =====
// Port level checks for the frame time capture monitor, bound to the top.
// Depends on ftcm_pkg and frame_time_capture_monitor_top.
`default_nettype none

module ftcm_checker import ftcm_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire in_word_t              s_data,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire out_word_t             m_data,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Only metric words carry an id and a value, and they are the only
    // words that come in a train.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_METRIC |->
            m_data.last && m_data.metric_id == 4'd0 && m_data.metric_value == '0)
        else $error("non-metric word malformed");

    // Only the flags metric closes a report.
    a_train: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_METRIC |->
            (m_data.last == (m_data.metric_id == M_FLAGS)))
        else $error("report train closed at the wrong metric");

    // The metric after an accepted non-final metric word is the next id.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.status == ST_METRIC && !m_data.last ##1 m_valid
            |-> m_data.status == ST_METRIC &&
                m_data.metric_id == $past(m_data.metric_id) + 4'd1)
        else $error("metric ids out of order");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind frame_time_capture_monitor_top ftcm_checker u_ftcm_checker (.*);

`default_nettype wire

// ===== tb/sv/frame_time_capture_monitor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the frame time capture monitor: watches the input, result and
// register channels, predicts every result word and compares it. Uses ftcm_pkg.
module frame_time_capture_monitor_checker import ftcm_pkg::*; #(
    parameter int unsigned MAX_FRAMES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire in_word_t              s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire out_word_t             m_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned                mismatches = 0,
    output int unsigned                waiting = 0
);

    localparam logic [28:0] PERIOD_CEIL = 29'h1FFF_FFFF;

    logic [25:0] warmup_reg;
    logic [28:0] duration_reg;
    logic [19:0] fast_reg;
    logic [19:0] slow_reg;
    logic [19:0] tol_reg;

    bit          capturing;
    bit          has_first;
    logic [47:0] first_ts;
    logic [47:0] prev_ts;
    logic [47:0] recorded;
    int unsigned frames;
    logic [28:0] periods [MAX_FRAMES];
    logic [28:0] ranked  [MAX_FRAMES];

    out_word_t   awaited_words [$];

    function automatic out_word_t make_word(logic [3:0] st, logic [3:0] id,
                                            logic [47:0] val, logic fin);
        out_word_t w;
        w.status = st;
        w.metric_id = id;
        w.metric_value = val;
        w.last = fin;
        return w;
    endfunction

    // Linear interpolation between neighbours of the sorted periods.
    function automatic longint unsigned interp_period(int unsigned n, int unsigned q);
        longint unsigned pos, lo, rem, up, a, b;
        pos = n - 1;
        pos = pos * q;
        lo  = pos / 100;
        rem = pos % 100;
        up  = (lo + 1 < n) ? lo + 1 : n - 1;
        a   = ranked[lo];
        b   = ranked[up];
        return (a << 8) + (((b - a) * 256 * rem + 50) / 100);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("%0t: %s mismatch, got %0h, awaited %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic compute_answers(in_word_t w);
        logic [47:0]     ts, per;
        longint unsigned v [13];
        longint unsigned worst, tot, fast_lim, slow_lim, p;
        int unsigned     i;
        int              j;
        logic [28:0]     key;
        ts = w.timestamp_us;
        case (w.func)
            FUNC_START: begin
                capturing = 1; has_first = 0;
                first_ts = '0; prev_ts = '0; recorded = '0; frames = 0;
                awaited_words.push_back(make_word(ST_STARTED, '0, '0, 1'b1));
            end
            FUNC_FRAME: begin
                if (!capturing) begin
                    awaited_words.push_back(make_word(ST_INACTIVE, '0, '0, 1'b1));
                end else if (!has_first) begin
                    has_first = 1; first_ts = ts; prev_ts = ts;
                    awaited_words.push_back(make_word(ST_PRIMED, '0, '0, 1'b1));
                end else if (ts <= prev_ts) begin
                    capturing = 0;
                    awaited_words.push_back(make_word(ST_NO_ADV, '0, '0, 1'b1));
                end else begin
                    per = ts - prev_ts;
                    if (prev_ts - first_ts < {22'd0, warmup_reg}) begin
                        prev_ts = ts;
                        awaited_words.push_back(make_word(ST_WARMUP, '0, '0, 1'b1));
                    end else if (frames >= MAX_FRAMES) begin
                        capturing = 0;
                        awaited_words.push_back(make_word(ST_CAP, '0, '0, 1'b1));
                    end else begin
                        // Long periods count in full but are stored saturated.
                        periods[frames] = (per > {19'd0, PERIOD_CEIL}) ? PERIOD_CEIL
                                                                       : per[28:0];
                        frames++;
                        recorded = recorded + per;
                        prev_ts = ts;
                        if (recorded >= {19'd0, duration_reg}) begin
                            capturing = 0;
                            awaited_words.push_back(make_word(ST_COMPLETE, '0, '0, 1'b1));
                        end else begin
                            awaited_words.push_back(make_word(ST_RECORDED, '0, '0, 1'b1));
                        end
                    end
                end
            end
            FUNC_REPORT: begin
                if (frames == 0) begin
                    awaited_words.push_back(make_word(ST_NO_FRAMES, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < frames; i++) ranked[i] = periods[i];
                    for (i = 1; i < frames; i++) begin
                        key = ranked[i];
                        j = i;
                        while (j > 0 && ranked[j-1] > key) begin
                            ranked[j] = ranked[j-1];
                            j--;
                        end
                        ranked[j] = key;
                    end
                    worst = ranked[frames-1];
                    fast_lim = fast_reg;
                    slow_lim = slow_reg;
                    for (i = 0; i < 13; i++) v[i] = 0;
                    for (i = 0; i < frames; i++) begin
                        p = periods[i];
                        if (p > fast_lim) v[M_OVER_FAST]++;
                        if (p > fast_lim + tol_reg) v[M_OVER_FTOL]++;
                        if (p > slow_lim) v[M_OVER_SLOW]++;
                        if (p > slow_lim + tol_reg) v[M_OVER_STOL]++;
                    end
                    tot = (recorded != 0) ? recorded : 1;
                    v[M_COUNT]   = frames;
                    v[M_TOTAL]   = recorded;
                    v[M_WORST]   = worst;
                    v[M_MIN_FPS] = (worst != 0) ? (256000000 + worst / 2) / worst : 0;
                    v[M_AVG_FPS] = (longint'(frames) * 256000000 + tot / 2) / tot;
                    v[M_P50]     = interp_period(frames, 50);
                    v[M_P95]     = interp_period(frames, 95);
                    v[M_P99]     = interp_period(frames, 99);
                    v[M_FLAGS]   = (v[M_OVER_FTOL] == 0 ? 1 : 0) | (v[M_OVER_STOL] == 0 ? 2 : 0);
                    for (i = 0; i < 13; i++)
                        awaited_words.push_back(make_word(ST_METRIC, 4'(i), v[i][47:0],
                                                          i == 12));
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            warmup_reg = WARMUP_RST; duration_reg = DURATION_RST;
            fast_reg = BFAST_RST; slow_reg = BSLOW_RST; tol_reg = TOL_RST;
            capturing = 0; has_first = 0;
            first_ts = '0; prev_ts = '0; recorded = '0; frames = 0;
            awaited_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WARMUP:   warmup_reg = cfg_data[25:0];
                    CFG_DURATION: duration_reg = cfg_data[28:0];
                    CFG_BFAST:    fast_reg = cfg_data[19:0];
                    CFG_BSLOW:    slow_reg = cfg_data[19:0];
                    CFG_TOL:      tol_reg = cfg_data[19:0];
                    default: ;
                endcase
            end
            // A result word leaving now cannot belong to a word entering now.
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("unexpected result word", m_data, 0);
                end else begin
                    want = awaited_words.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.metric_id !== want.metric_id)
                        report_mismatch("metric_id", m_data.metric_id, want.metric_id);
                    if (m_data.metric_value !== want.metric_value)
                        report_mismatch("metric_value", m_data.metric_value,
                                        want.metric_value);
                    if (m_data.last !== want.last)
                        report_mismatch("last", m_data.last, want.last);
                end
            end
            if (s_valid && s_ready) compute_answers(s_data);
        end
        waiting <= awaited_words.size();
    end

endmodule

// ===== tb/sv/frame_time_capture_monitor_top_test.sv =====
`timescale 1ns / 100ps
// Top of the frame time capture monitor testbench: clock, reset, stimulus and
// verdict. Depends on ftcm_pkg, the block and frame_time_capture_monitor_checker.
module frame_time_capture_monitor_top_test;
    import ftcm_pkg::*;

    // A small frame cap keeps reports short and lets the cap be reached.
    localparam int unsigned CAP_FRAMES = 16;
    localparam int unsigned LIMIT      = 1500000;
    localparam int unsigned SETTLE     = 16;
    localparam int unsigned ITEM_GOAL  = 260;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned mismatches, waiting;
    int unsigned cycles = 0;
    int unsigned items = 0;
    int unsigned reports = 0;
    int unsigned reg_writes = 0;
    int unsigned captures = 0;
    // While set, neither side idles.
    bit          steady = 0;

    frame_time_capture_monitor_top #(.MAX_FRAMES(CAP_FRAMES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    frame_time_capture_monitor_checker #(.MAX_FRAMES(CAP_FRAMES)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .waiting(waiting)
    );

    always #6 aclk = ~aclk;

    // The result side stalls at random, 38 percent of the time, except in the
    // steady stretch where it takes every word at once.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 38);
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one input word. An optional idle gap comes first; then valid is
    // raised and held with the payload until the block takes the word. The
    // task returns in the time step of the accepting edge, so the next call
    // drives valid only once in that step.
    task automatic send_word(logic [1:0] fn, logic [47:0] ts);
        int unsigned gap;
        gap = (!steady && $urandom_range(0, 99) < 38) ? $urandom_range(1, 5) : 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{func: fn, timestamp_us: ts};
        do @(posedge aclk); while (!s_ready);
        if (fn != 2'b11) items++;
        if (fn == FUNC_REPORT) reports++;
    endtask

    // Holds the input side until every awaited result word has arrived, then
    // lets the block settle, since an ignored word produces nothing to wait on.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write; call only after drain so the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // Picks a register value: an extreme, the reset value, something typical,
    // or now and then a raw 32-bit word that the block truncates.
    function automatic logic [CFG_DATA_W-1:0] pick_value(logic [CFG_IDX_W-1:0] idx);
        int unsigned lo, hi, dflt, roll;
        case (idx)
            CFG_WARMUP:   begin lo = 0;       hi = 60000000;  dflt = WARMUP_RST;   end
            CFG_DURATION: begin lo = 1000000; hi = 300000000; dflt = DURATION_RST; end
            CFG_BFAST:    begin lo = 1;       hi = 1000000;   dflt = BFAST_RST;    end
            CFG_BSLOW:    begin lo = 1;       hi = 1000000;   dflt = BSLOW_RST;    end
            default:      begin lo = 0;       hi = 1000000;   dflt = TOL_RST;      end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 15) return lo;
        if (roll < 25) return hi;
        if (roll < 40) return dflt;
        if (roll < 45) return $urandom();
        if (idx == CFG_WARMUP) return $urandom_range(0, 300000);
        if (idx == CFG_DURATION) return $urandom_range(lo, 3000000);
        return $urandom_range(lo, 80000);
    endfunction

    // One capture: a start, a priming boundary and a run of boundaries whose
    // periods mostly stay within top_period, with occasional stalled clocks,
    // very long periods and reports in between; usually a closing report.
    // With hold set, the sender waits halfway for every result to come back.
    task automatic run_capture(int unsigned nframes, int unsigned top_period, bit hold);
        logic [47:0] ts;
        int unsigned k, roll;
        ts = {1'b0, 15'($urandom_range(0, 32767)), 32'($urandom())};
        captures++;
        send_word(FUNC_START, '0);
        send_word(FUNC_FRAME, ts);
        for (k = 0; k < nframes; k++) begin
            if (hold && k == nframes / 2) drain();
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // The clock stands still or steps back.
                send_word(FUNC_FRAME, ts - $urandom_range(0, 5));
            end else if (roll < 6) begin
                ts = ts + (48'd1 << 29) + $urandom_range(0, 32'h3FFF_FFFF);
                send_word(FUNC_FRAME, ts);
            end else begin
                ts = ts + $urandom_range(1, top_period);
                send_word(FUNC_FRAME, ts);
                if (roll < 9) send_word(FUNC_REPORT, {16'($urandom()), 32'($urandom())});
            end
        end
        if ($urandom_range(0, 99) < 80) send_word(FUNC_REPORT, '0);
    endtask

    initial begin
        int unsigned round, pick, nregs, r, scale;
        logic [CFG_IDX_W-1:0] idx;
        logic [1:0] fn;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Boundary and report before any start, then a stalled
        // clock right after priming, which ends the capture, and a boundary after it.
        send_word(FUNC_FRAME, '0);
        send_word(FUNC_REPORT, '0);
        send_word(FUNC_START, '0);
        send_word(FUNC_FRAME, 48'd1000);
        send_word(FUNC_FRAME, 48'd1000);
        send_word(FUNC_FRAME, 48'd2000);
        // Two recorded frames, then a period too long to store unsaturated,
        // which also completes the default duration; then the full report.
        send_word(FUNC_START, '0);
        send_word(FUNC_FRAME, 48'd100);
        send_word(FUNC_FRAME, 48'd16767);
        send_word(FUNC_FRAME, 48'd56767);
        send_word(FUNC_FRAME, 48'd56767 + (48'd1 << 30));
        send_word(FUNC_REPORT, '0);
        // The unused function code with every timestamp bit set is ignored.
        send_word(2'b11, '1);
        // Priming at the top of the timestamp range, then a wrap to zero.
        send_word(FUNC_START, '0);
        send_word(FUNC_FRAME, '1);
        send_word(FUNC_FRAME, '0);

        // Extremes, first set: longest warmup, shortest duration.
        drain();
        write_reg(CFG_WARMUP, 32'd60000000);
        write_reg(CFG_DURATION, 32'd1000000);
        write_reg(CFG_BFAST, 32'd1);
        write_reg(CFG_BSLOW, 32'd1000000);
        write_reg(CFG_TOL, 32'd0);
        // A frame that begins inside warmup and ends after it is still
        // excluded; the next one is recorded and completes at once.
        send_word(FUNC_START, '0);
        send_word(FUNC_FRAME, 48'd0);
        send_word(FUNC_FRAME, 48'd30000000);
        send_word(FUNC_FRAME, 48'd70000000);
        send_word(FUNC_FRAME, 48'd71000000);
        send_word(FUNC_REPORT, '0);

        // Extremes, second set.
        drain();
        write_reg(CFG_WARMUP, 32'd0);
        write_reg(CFG_DURATION, 32'd300000000);
        write_reg(CFG_BFAST, 32'd1000000);
        write_reg(CFG_BSLOW, 32'd1);
        write_reg(CFG_TOL, 32'd1000000);

        // Random part: mostly complete captures with random content, some
        // register changes in idle time and a share of noise words.
        round = 0;
        while (items < ITEM_GOAL) begin
            round++;
            steady = (round >= 4 && round < 9);
            if ($urandom_range(0, 2) == 0) begin
                drain();
                nregs = $urandom_range(1, 3);
                for (r = 0; r < nregs; r++) begin
                    idx = CFG_IDX_W'($urandom_range(0, 4));
                    write_reg(idx, pick_value(idx));
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                fn = 2'($urandom());
                send_word(fn, {16'($urandom()), 32'($urandom())});
            end else begin
                case ($urandom_range(0, 2))
                    0:       scale = 40000;
                    1:       scale = 200000;
                    default: scale = 2000000;
                endcase
                run_capture($urandom_range(1, CAP_FRAMES + 6), scale, round == 12);
            end
        end
        drain();

        $display("Covered %0d input words in %0d captures, %0d reports, %0d register writes.",
                 items, captures, reports, reg_writes);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== frame_time_capture_monitor_top.f =====
rtl/ftcm_pkg.sv
rtl/ftcm_ram.sv
rtl/ftcm_div.sv
rtl/ftcm_ctrl.sv
rtl/ftcm_dp.sv
rtl/frame_time_capture_monitor_top.sv
rtl/ftcm_checker.sv
tb/sv/frame_time_capture_monitor_checker.sv
tb/sv/frame_time_capture_monitor_top_test.sv
